// File: hdl/nnsc_pkg.sv
// nnsc_pkg: shared types and constants for the nearest neighbor RGB565 scaler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nnsc_pkg;

  // Fixed field widths
  localparam int CNT_W   = 4;   // replica count, holds up to 15, capped at MAX_UPSCALE
  localparam int POS_W   = 12;  // source and destination positions
  localparam int DIM_W   = 13;  // source sizes and clipped screen sizes
  localparam int IMG_W   = 12;  // image and screen register width
  localparam int COLOR_W = 16;
  localparam int INDEX_W = 22;
  localparam int CFG_W   = 13;
  localparam int NUM_W   = POS_W + DIM_W;  // product fed to the divider
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Register indexes
  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_IMAGE_WIDTH   = 3'd4,
    REG_IMAGE_HEIGHT  = 3'd5,
    REG_SCALE_MODE    = 3'd6
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [IMG_W-1:0] RST_SCREEN_WIDTH  = 12'd320;
  localparam logic [IMG_W-1:0] RST_SCREEN_HEIGHT = 12'd240;
  localparam logic [DIM_W-1:0] RST_SOURCE_WIDTH  = 13'd320;
  localparam logic [DIM_W-1:0] RST_SOURCE_HEIGHT = 13'd240;
  localparam logic [IMG_W-1:0] RST_IMAGE_WIDTH   = 12'd320;
  localparam logic [IMG_W-1:0] RST_IMAGE_HEIGHT  = 12'd240;

  // Settings seen by the mapping front end
  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [IMG_W-1:0] img_w;
    logic [IMG_W-1:0] img_h;
    logic             scale;
  } scan_cfg_t;

  // Screen geometry seen by the write back end
  typedef struct packed {
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [IMG_W-1:0] startx;
    logic [IMG_W-1:0] starty;
  } geom_t;

  // One block of replica writes for one source pixel
  typedef struct packed {
    logic [POS_W-1:0]   first_row;
    logic [CNT_W-1:0]   rows;
    logic [POS_W-1:0]   first_col;
    logic [CNT_W-1:0]   cols;
    logic [COLOR_W-1:0] color;
  } job_t;

  // RGB888 to RGB565: top bits of each component
  function automatic logic [COLOR_W-1:0] rgb565(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// File: hdl/nnsc_div.sv
// nnsc_div: serial restoring divider, one quotient bit per cycle, with
// round-half-down of the quotient. Depends on nnsc_pkg.
`timescale 1ns / 1ps

module nnsc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [nnsc_pkg::NUM_W-1:0] num,
  input  logic [nnsc_pkg::IMG_W-1:0] den,
  output logic                      done,
  output logic [nnsc_pkg::DIM_W-1:0] quot
);
  import nnsc_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t          state_r;
  logic [4:0]       cnt_r;
  logic [NUM_W-1:0] q_r;
  logic [IMG_W-1:0] rem_r;
  logic [IMG_W-1:0] den_r;
  logic             done_r;
  logic [DIM_W-1:0] quot_r;

  // one restoring step
  logic [IMG_W:0] trial;
  logic           fits;
  logic           round_up;
  assign trial    = {rem_r, q_r[NUM_W-1]};
  assign fits     = trial >= {1'b0, den_r};
  assign round_up = rem_r > (den_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            q_r     <= num;
            rem_r   <= '0;
            den_r   <= den;
            cnt_r   <= 5'(NUM_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (fits) rem_r <= IMG_W'(trial - {1'b0, den_r});
          else      rem_r <= trial[IMG_W-1:0];
          q_r <= {q_r[NUM_W-2:0], fits};
          if (cnt_r == '0) state_r <= D_FIN;
          else             cnt_r <= cnt_r - 5'd1;
        end
        D_FIN: begin
          // zero divisor maps everything to zero
          if (den_r == '0) quot_r <= '0;
          else             quot_r <= q_r[DIM_W-1:0] + DIM_W'(round_up);
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: hdl/nnsc_front.sv
// nnsc_front: accepts source pixels, tracks raster position and walks the
// destination row/column maps. Depends on nnsc_pkg and nnsc_div.
`timescale 1ns / 1ps

module nnsc_front #(
  parameter int MAX_UPSCALE = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic                  in_frame_start,
  input  nnsc_pkg::scan_cfg_t   cfg,
  output logic                  job_valid,
  input  logic                  job_ready,
  output nnsc_pkg::job_t        job
);
  import nnsc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_ROW, S_ROW_DIV, S_COL, S_COL_DIV, S_PUSH} fstate_t;

  fstate_t            state_r;
  logic [COLOR_W-1:0] color_r;
  logic [POS_W-1:0]   src_col_r, src_row_r;
  logic [POS_W-1:0]   nd_col_r, nd_row_r;
  logic [DIM_W-1:0]   nd_col_src_r, nd_row_src_r;
  logic [POS_W-1:0]   first_row_r, first_col_r;
  logic [CNT_W-1:0]   row_cnt_r, col_cnt_r;

  logic [CNT_W-1:0] max_cnt;
  assign max_cnt = CNT_W'(MAX_UPSCALE);

  // loop conditions of the two map walks
  logic row_go, col_go, row_hit, col_hit;
  assign row_go  = (nd_row_r < cfg.img_h) && (nd_row_src_r <= {1'b0, src_row_r});
  assign col_go  = (nd_col_r < cfg.img_w) && (nd_col_src_r <= {1'b0, src_col_r});
  assign row_hit = (nd_row_src_r == {1'b0, src_row_r}) && ({1'b0, src_row_r} < cfg.src_h);
  assign col_hit = (nd_col_src_r == {1'b0, src_col_r}) && ({1'b0, src_col_r} < cfg.src_w);

  // divider feed: next destination index times source size
  logic             div_start, div_done, div_row;
  logic [POS_W-1:0] nd_row_inc, nd_col_inc;
  logic [NUM_W-1:0] div_num;
  logic [IMG_W-1:0] div_den;
  logic [DIM_W-1:0] div_quot;
  assign nd_row_inc = POS_W'(nd_row_r + 1'b1);
  assign nd_col_inc = POS_W'(nd_col_r + 1'b1);
  assign div_row    = state_r == S_ROW;
  assign div_start  = (div_row && row_go) || (state_r == S_COL && col_go);
  assign div_num    = div_row ? NUM_W'(nd_row_inc * cfg.src_h) : NUM_W'(nd_col_inc * cfg.src_w);
  assign div_den    = div_row ? cfg.img_h : cfg.img_w;

  nnsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // raster advance at the end of a pixel
  logic col_wrap, row_wrap;
  assign col_wrap = ({1'b0, src_col_r} + 13'd1) >= cfg.src_w;
  assign row_wrap = ({1'b0, src_row_r} + 13'd1) >= cfg.src_h;

  logic src_col_zero;
  assign src_col_zero = in_frame_start || (src_col_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      src_col_r    <= '0;
      src_row_r    <= '0;
      nd_col_r     <= '0;
      nd_row_r     <= '0;
      nd_col_src_r <= '0;
      nd_row_src_r <= '0;
      first_row_r  <= '0;
      row_cnt_r    <= '0;
      first_col_r  <= '0;
      col_cnt_r    <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            color_r <= rgb565(in_red, in_green, in_blue);
            if (in_frame_start) begin
              src_col_r    <= '0;
              src_row_r    <= '0;
              nd_col_r     <= '0;
              nd_row_r     <= '0;
              nd_col_src_r <= '0;
              nd_row_src_r <= '0;
            end
            // row block restarts on a new frame or a new scaled row
            if (in_frame_start || (cfg.scale && src_col_zero)) begin
              first_row_r <= '0;
              row_cnt_r   <= '0;
            end
            first_col_r <= '0;
            col_cnt_r   <= '0;
            if (!cfg.scale) begin
              state_r <= S_PUSH;
            end else if (src_col_zero) begin
              state_r <= S_ROW;
            end else begin
              state_r <= S_COL;
            end
          end
        end
        S_ROW: begin
          if (row_go) begin
            if (row_hit) begin
              if (row_cnt_r == '0) first_row_r <= nd_row_r;
              if (row_cnt_r < max_cnt) row_cnt_r <= row_cnt_r + 1'b1;
            end
            nd_row_r <= nd_row_inc;
            state_r  <= S_ROW_DIV;
          end else begin
            state_r <= S_COL;
          end
        end
        S_ROW_DIV: begin
          if (div_done) begin
            nd_row_src_r <= div_quot;
            state_r      <= S_ROW;
          end
        end
        S_COL: begin
          if (col_go) begin
            if (col_hit) begin
              if (col_cnt_r == '0) first_col_r <= nd_col_r;
              if (col_cnt_r < max_cnt) col_cnt_r <= col_cnt_r + 1'b1;
            end
            nd_col_r <= nd_col_inc;
            state_r  <= S_COL_DIV;
          end else begin
            state_r <= S_PUSH;
          end
        end
        S_COL_DIV: begin
          if (div_done) begin
            nd_col_src_r <= div_quot;
            state_r      <= S_COL;
          end
        end
        S_PUSH: begin
          if (job_ready) begin
            if (col_wrap) begin
              src_col_r    <= '0;
              nd_col_r     <= '0;
              nd_col_src_r <= '0;
              if (row_wrap) begin
                src_row_r    <= '0;
                nd_row_r     <= '0;
                nd_row_src_r <= '0;
              end else begin
                src_row_r <= src_row_r + 1'b1;
              end
            end else begin
              src_col_r <= src_col_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // job word: scaled block, or a single write in copy mode
  always_comb begin
    job.color = color_r;
    if (cfg.scale) begin
      job.first_row = first_row_r;
      job.rows      = row_cnt_r;
      job.first_col = first_col_r;
      job.cols      = col_cnt_r;
    end else begin
      job.first_row = src_row_r;
      job.rows      = CNT_W'(1);
      job.first_col = src_col_r;
      job.cols      = CNT_W'(1);
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign job_valid = state_r == S_PUSH;

endmodule

// File: hdl/nnsc_fifo.sv
// nnsc_fifo: short register queue of job words between front and back end.
// Depends on nnsc_pkg.
`timescale 1ns / 1ps

module nnsc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  nnsc_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output nnsc_pkg::job_t pop_data
);
  import nnsc_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  logic push, pop;
  assign push_ready = count_r != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hdl/nnsc_back.sv
// nnsc_back: clips a job to the screen and emits its framebuffer words,
// one per cycle unless out_ready stalls, through a registered output. Depends on nnsc_pkg.
`timescale 1ns / 1ps

module nnsc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  nnsc_pkg::job_t               job,
  input  nnsc_pkg::geom_t              geom,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nnsc_pkg::INDEX_W-1:0] out_pixel_index,
  output logic [nnsc_pkg::COLOR_W-1:0] out_color,
  output logic                         out_last
);
  import nnsc_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_SETUP, B_EMIT} bstate_t;

  bstate_t            state_r;
  job_t               job_r;
  logic [DIM_W-1:0]   row_abs_r, col_abs_r;
  logic [CNT_W-1:0]   nr_r, nc_r, i_r, j_r;
  logic               out_valid_r, out_last_r;
  logic [INDEX_W-1:0] index_r;
  logic [COLOR_W-1:0] color_r;

  // clipping against the screen edges
  logic [DIM_W-1:0] row_abs, col_abs, row_room, col_room;
  logic [CNT_W-1:0] nr, nc;
  assign row_abs  = DIM_W'(job_r.first_row) + DIM_W'(geom.starty);
  assign col_abs  = DIM_W'(job_r.first_col) + DIM_W'(geom.startx);
  assign row_room = (geom.sh > row_abs) ? DIM_W'(geom.sh - row_abs) : '0;
  assign col_room = (geom.sw > col_abs) ? DIM_W'(geom.sw - col_abs) : '0;
  assign nr = (row_room < DIM_W'(job_r.rows)) ? row_room[CNT_W-1:0] : job_r.rows;
  assign nc = (col_room < DIM_W'(job_r.cols)) ? col_room[CNT_W-1:0] : job_r.cols;

  // address of the current write
  logic [DIM_W-1:0] row_cur, col_cur;
  logic [31:0]      addr;
  logic             load, end_row, end_job;
  assign row_cur = DIM_W'(row_abs_r + DIM_W'(i_r));
  assign col_cur = DIM_W'(col_abs_r + DIM_W'(j_r));
  assign addr    = 32'(row_cur) * 32'(geom.sw) + 32'(col_cur);
  assign load    = (state_r == B_EMIT) && (!out_valid_r || out_ready);
  assign end_row = j_r == CNT_W'(nc_r - 1'b1);
  assign end_job = end_row && (i_r == CNT_W'(nr_r - 1'b1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (out_ready && !load) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            state_r <= B_SETUP;
          end
        end
        B_SETUP: begin
          row_abs_r <= row_abs;
          col_abs_r <= col_abs;
          nr_r      <= nr;
          nc_r      <= nc;
          i_r       <= '0;
          j_r       <= '0;
          // fully clipped jobs make no write
          if (nr == '0 || nc == '0) state_r <= B_IDLE;
          else                      state_r <= B_EMIT;
        end
        B_EMIT: begin
          if (load) begin
            out_valid_r <= 1'b1;
            index_r     <= addr[INDEX_W-1:0];
            color_r     <= job_r.color;
            out_last_r  <= end_job;
            if (end_job) begin
              state_r <= B_IDLE;
            end else if (end_row) begin
              j_r <= '0;
              i_r <= i_r + 1'b1;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign job_ready       = state_r == B_IDLE;
  assign out_valid       = out_valid_r;
  assign out_pixel_index = index_r;
  assign out_color       = color_r;
  assign out_last        = out_last_r;

endmodule

// File: hdl/nearest_neighbor_scaler_rgb565.sv
// Nearest neighbor scaler, RGB888 pixel stream in, RGB565 framebuffer words out.
// Each accepted pixel walks the destination columns, and the rows at a new source
// row, each step examined by the serial divider (25-step map evaluation); the back
// end then takes a setup state and emits one word per cycle while out_ready does
// not stall it. Throughput is set by that divider loop; copy mode skips the walks.
// Reset: synchronous, active low; registers return to 320x240, scaling on.
`timescale 1ns / 1ps

module nearest_neighbor_scaler_rgb565 #(
  parameter int MAX_SCREEN_WIDTH  = 2048,
  parameter int MAX_SCREEN_HEIGHT = 2048,
  parameter int MAX_UPSCALE       = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nnsc_pkg::INDEX_W-1:0] out_pixel_index,
  output logic [nnsc_pkg::COLOR_W-1:0] out_color,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [nnsc_pkg::CFG_W-1:0]   cfg_wdata
);
  import nnsc_pkg::*;

  // configuration registers
  logic [IMG_W-1:0] scr_w_r, scr_h_r, img_w_r, img_h_r;
  logic [DIM_W-1:0] src_w_r, src_h_r;
  logic             scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= RST_SCREEN_WIDTH;
      scr_h_r <= RST_SCREEN_HEIGHT;
      src_w_r <= RST_SOURCE_WIDTH;
      src_h_r <= RST_SOURCE_HEIGHT;
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      scale_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata[IMG_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata[IMG_W-1:0];
        REG_SOURCE_WIDTH:  src_w_r <= cfg_wdata;
        REG_SOURCE_HEIGHT: src_h_r <= cfg_wdata;
        REG_IMAGE_WIDTH:   img_w_r <= cfg_wdata[IMG_W-1:0];
        REG_IMAGE_HEIGHT:  img_h_r <= cfg_wdata[IMG_W-1:0];
        REG_SCALE_MODE:    scale_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // screen limits and centering offsets
  scan_cfg_t scan_cfg;
  geom_t     geom;
  assign geom.sw = (DIM_W'(scr_w_r) > DIM_W'(MAX_SCREEN_WIDTH)) ?
                   DIM_W'(MAX_SCREEN_WIDTH) : DIM_W'(scr_w_r);
  assign geom.sh = (DIM_W'(scr_h_r) > DIM_W'(MAX_SCREEN_HEIGHT)) ?
                   DIM_W'(MAX_SCREEN_HEIGHT) : DIM_W'(scr_h_r);
  assign geom.startx = (DIM_W'(img_w_r) < geom.sw) ?
                       IMG_W'((geom.sw - DIM_W'(img_w_r)) >> 1) : '0;
  assign geom.starty = (DIM_W'(img_h_r) < geom.sh) ?
                       IMG_W'((geom.sh - DIM_W'(img_h_r)) >> 1) : '0;

  assign scan_cfg.src_w = src_w_r;
  assign scan_cfg.src_h = src_h_r;
  assign scan_cfg.img_w = img_w_r;
  assign scan_cfg.img_h = img_h_r;
  assign scan_cfg.scale = scale_r;

  // front end, queue, back end
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  nnsc_front #(.MAX_UPSCALE(MAX_UPSCALE)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_frame_start (in_frame_start),
    .cfg            (scan_cfg),
    .job_valid      (f_valid),
    .job_ready      (f_ready),
    .job            (f_job)
  );

  nnsc_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_job)
  );

  nnsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (b_valid),
    .job_ready       (b_ready),
    .job             (b_job),
    .geom            (geom),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_color       (out_color),
    .out_last        (out_last)
  );

  // front end takes one word at a time
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front end accepted while busy");

  // a pushed job is visible to the back end on the next cycle
  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && f_ready) |=> b_valid)
    else $error("queue lost a job");

endmodule

// File: tb/sv/nearest_neighbor_scaler_rgb565_test.sv
// Self-checking testbench for the nearest neighbor RGB565 scaler.
// Needs nnsc_pkg and nearest_neighbor_scaler_rgb565; drives pixel words, predicts
// framebuffer writes with a behavioral scaler model and compares them in order.
`timescale 1ns / 1ps

module nearest_neighbor_scaler_rgb565_test;
  import nnsc_pkg::*;

  typedef struct {
    logic [7:0] r, g, b;
    logic       fs;
    logic       hold;  // wait for all expected writes before sending
  } pixel_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [INDEX_W-1:0] out_pixel_index;
  logic [COLOR_W-1:0] out_color;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pixel_t      pixel_queue[$];
  fb_write_t   write_queue[$];
  pixel_t      cur_px;
  int unsigned tx_idle = 0, rx_idle = 0;
  int unsigned mismatches = 0;

  // scaler model registers and state
  int unsigned scr_w, scr_h, src_w, src_h, img_w, img_h, scale_on;
  int unsigned src_col, src_row, nxt_col, nxt_col_src;
  int unsigned row_first, row_cnt, nxt_row, nxt_row_src;

  nearest_neighbor_scaler_rgb565 dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned map_source(int unsigned k, int unsigned src,
                                             int unsigned img);
    longint unsigned n, q, rem;
    if (img == 0) return 0;
    n = longint'(k) * src;
    q = n / img;
    rem = n % img;
    if (rem > img / 2) q++;
    return int'(q & 64'h1FFF);
  endfunction

  function automatic int unsigned center_off(int unsigned scr, int unsigned img);
    return (img < scr) ? (scr - img) / 2 : 0;
  endfunction

  // Model one accepted pixel word: push its framebuffer writes
  task automatic predict_writes(pixel_t p);
    logic [15:0] c;
    int unsigned sw, sh, x0, y0, sc, sr, fcol, ccnt, row, col, n;
    fb_write_t w;
    c = {p.r[7:3], p.g[7:2], p.b[7:3]};
    sw = (scr_w > 2048) ? 2048 : scr_w;
    sh = (scr_h > 2048) ? 2048 : scr_h;
    x0 = center_off(sw, img_w);
    y0 = center_off(sh, img_h);
    n = 0;
    fcol = 0;
    ccnt = 0;
    if (p.fs) begin
      src_col = 0; src_row = 0; nxt_col = 0; nxt_col_src = 0;
      nxt_row = 0; nxt_row_src = 0; row_first = 0; row_cnt = 0;
    end
    sc = src_col;
    sr = src_row;
    if (scale_on != 0) begin
      // new source row: collect the destination rows that map to it
      if (sc == 0) begin
        row_first = 0;
        row_cnt = 0;
        while (nxt_row < img_h && nxt_row_src <= sr) begin
          if (nxt_row_src == sr && sr < src_h) begin
            if (row_cnt == 0) row_first = nxt_row;
            if (row_cnt < 8) row_cnt++;
          end
          nxt_row = (nxt_row + 1) & 12'hFFF;
          nxt_row_src = map_source(nxt_row, src_h, img_h);
        end
      end
      while (nxt_col < img_w && nxt_col_src <= sc) begin
        if (nxt_col_src == sc && sc < src_w) begin
          if (ccnt == 0) fcol = nxt_col;
          if (ccnt < 8) ccnt++;
        end
        nxt_col = (nxt_col + 1) & 12'hFFF;
        nxt_col_src = map_source(nxt_col, src_w, img_w);
      end
      for (int i = 0; i < row_cnt; i++) begin
        row = row_first + i + y0;
        if (row < sh) begin
          for (int j = 0; j < ccnt; j++) begin
            col = fcol + j + x0;
            if (col < sw) begin
              w.index = INDEX_W'(row * sw + col);
              w.color = c;
              w.last = 1'b0;
              write_queue.push_back(w);
              n++;
            end
          end
        end
      end
    end else begin
      row = sr + y0;
      col = sc + x0;
      if (row < sh && col < sw) begin
        w.index = INDEX_W'(row * sw + col);
        w.color = c;
        w.last = 1'b0;
        write_queue.push_back(w);
        n = 1;
      end
    end
    if (n > 0) write_queue[write_queue.size() - 1].last = 1'b1;
    // advance raster position
    if (sc + 1 >= src_w) begin
      src_col = 0; nxt_col = 0; nxt_col_src = 0;
      if (sr + 1 >= src_h) begin
        src_row = 0; nxt_row = 0; nxt_row_src = 0;
      end else begin
        src_row = (sr + 1) & 12'hFFF;
      end
    end else begin
      src_col = (sc + 1) & 12'hFFF;
    end
  endtask

  // Pixel word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_writes(cur_px);
      if (!in_valid || in_ready) begin
        if (pixel_queue.size() > 0 && !(pixel_queue[0].hold && write_queue.size() > 0) &&
            $urandom_range(99) >= tx_idle) begin
          cur_px = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_red <= cur_px.r;
          in_green <= cur_px.g;
          in_blue <= cur_px.b;
          in_frame_start <= cur_px.fs;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Write monitor
  always @(posedge clk) begin
    fb_write_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
      if (out_valid && out_ready) begin
        if (write_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected write: index %0d color %h last %b",
                     out_pixel_index, out_color, out_last);
        end else begin
          e = write_queue.pop_front();
          if (e.index !== out_pixel_index || e.color !== out_color || e.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("write mismatch: exp index %0d color %h last %b, got %0d %h %b",
                       e.index, e.color, e.last, out_pixel_index, out_color, out_last);
          end
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = val & 12'hFFF;
      REG_SCREEN_HEIGHT: scr_h = val & 12'hFFF;
      REG_SOURCE_WIDTH:  src_w = val & 13'h1FFF;
      REG_SOURCE_HEIGHT: src_h = val & 13'h1FFF;
      REG_IMAGE_WIDTH:   img_w = val & 12'hFFF;
      REG_IMAGE_HEIGHT:  img_h = val & 12'hFFF;
      REG_SCALE_MODE:    scale_on = val & 1;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(int unsigned sw, int unsigned sh, int unsigned srw, int unsigned srh,
                       int unsigned iw, int unsigned ih, int unsigned mode);
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_SOURCE_WIDTH, srw);
    write_reg(REG_SOURCE_HEIGHT, srh);
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_SCALE_MODE, mode);
  endtask

  // Queue random pixels; first one starts a frame, a few stray frame starts
  task automatic add_pixels(int unsigned count, int unsigned hold_at);
    pixel_t p;
    for (int k = 0; k < count; k++) begin
      p.r = 8'($urandom);
      p.g = 8'($urandom);
      p.b = 8'($urandom);
      p.fs = (k == 0) || ($urandom_range(24) == 0);
      p.hold = (k == hold_at);
      pixel_queue.push_back(p);
    end
  endtask

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    pixel_t p;
    p.r = r; p.g = g; p.b = b; p.fs = fs; p.hold = 1'b0;
    pixel_queue.push_back(p);
  endtask

  // Wait for all words sent and all writes seen, then let the front end settle
  task automatic drain();
    while (!(pixel_queue.size() == 0 && !in_valid && write_queue.size() == 0))
      @(posedge clk);
    repeat (30 * (img_w + img_h + 4) + 50) @(posedge clk);
  endtask

  initial begin
    scr_w = 320; scr_h = 240; src_w = 320; src_h = 240;
    img_w = 320; img_h = 240; scale_on = 1;
    src_col = 0; src_row = 0; nxt_col = 0; nxt_col_src = 0;
    row_first = 0; row_cnt = 0; nxt_row = 0; nxt_row_src = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, color extremes, mid-frame start
    tx_idle = 9; rx_idle = 58;
    add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    add_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    add_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    add_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    add_pixel(8'hA5, 8'h5A, 8'h07, 1'b0);
    add_pixel(8'h07, 8'h03, 8'hF8, 1'b1);
    drain();
    // single pixel everywhere, scale mode at one to one
    setup(1, 1, 1, 1, 1, 1, 1);
    add_pixel(8'h80, 8'h40, 8'h20, 1'b1);
    add_pixel(8'h7F, 8'hBF, 8'hDF, 1'b0);
    drain();
    // zero image size: nothing written in scale mode
    setup(16, 16, 4, 4, 0, 0, 1);
    add_pixels(6, 99);
    drain();
    // zero screen in copy mode
    setup(0, 0, 4, 4, 4, 4, 0);
    add_pixels(6, 99);
    drain();
    // upscale beyond eight copies, clipped by the screen
    setup(20, 20, 3, 2, 40, 30, 1);
    add_pixels(24, 99);
    drain();

    // random: modest upscale centered, one pause mid stream
    tx_idle = 58; rx_idle = 9;
    setup(16, 12, 4, 3, 10, 7, 1);
    add_pixels(30, 14);
    drain();
    // downscale on the largest screen
    setup(2048, 2048, 12, 10, 5, 4, 1);
    add_pixels(40, 99);
    drain();
    // copy mode clipped, then centered
    setup(6, 5, 8, 7, 8, 7, 0);
    add_pixels(30, 99);
    drain();

    tx_idle = 0; rx_idle = 0;
    setup(10, 10, 4, 3, 4, 3, 0);
    add_pixels(20, 99);
    drain();
    // oversize registers: screen saturates, huge source rows
    setup(4095, 4095, 8191, 8191, 6, 5, 1);
    add_pixels(20, 99);
    drain();
    // image as wide as the largest screen from a single source pixel
    setup(2048, 8, 1, 1, 2048, 2, 1);
    add_pixels(3, 99);
    drain();
    setup(7, 9, 5, 5, 13, 11, 1);
    add_pixels(30, 99);
    drain();

    if (mismatches == 0) begin
      $display("nearest_neighbor_scaler_rgb565 regression: pass");
    end else begin
      $display("nearest_neighbor_scaler_rgb565 regression: fail");
    end
    $finish;
  end

  // run time guard
  initial begin
    #30ms;
    $display("nearest_neighbor_scaler_rgb565 regression: fail");
    $finish;
  end

endmodule
